/* hdl/msq_pkg.sv */
// Shared types and constants for the multi-track note sequencer.
// Request and result payload structs, operation codes and controller states.
// No dependencies.
package msq_pkg;

    localparam int CHANNELS_DEF        = 4;
    localparam int NOTES_PER_TRACK_DEF = 256;

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_START  = 3'd1,
        OP_PLAY   = 3'd2,
        OP_PAUSE  = 3'd3,
        OP_LOAD   = 3'd4,
        OP_LEGATO = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_NOTE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [1:0]  track;
        logic [7:0]  note_index;
        logic [15:0] interval;
        logic [15:0] pitch;
        logic [15:0] legato_ticks;
    } req_t;

    typedef struct packed {
        logic [1:0]  channel;
        logic        sound_on;
        logic [15:0] tone_pitch;
        logic        track_end;
        logic        song_end;
        logic        last;
    } rsp_t;

endpackage

/* hdl/msq_note_mem.sv */
// Note store: one write port, one registered read port.
// Each word holds {pitch, interval}. Depends on nothing.
module msq_note_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/msq_seq_ctrl.sv */
// Sequencer control: per-track state, request decode, tick scan and result walk.
// Uses msq_pkg types; drives the ports of msq_note_mem.
module msq_seq_ctrl #(
    parameter int CHANNELS        = msq_pkg::CHANNELS_DEF,
    parameter int NOTES_PER_TRACK = msq_pkg::NOTES_PER_TRACK_DEF,
    parameter int AW              = 10
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  msq_pkg::req_t req,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_data,
    output logic          mem_we,
    output logic [AW-1:0] mem_waddr,
    output logic [31:0]   mem_wdata,
    output logic          mem_re,
    output logic [AW-1:0] mem_raddr,
    input  logic [31:0]   mem_rdata,
    output logic          result_valid,
    output msq_pkg::rsp_t result
);

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PW = $clog2(NOTES_PER_TRACK);

    msq_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   ch_reg, ch_next;
    logic            playing_reg, playing_next;
    logic [2:0]      tracks_reg;
    logic            remain_reg, remain_next;
    logic            song_reg, song_next;
    logic [CHANNELS-1:0] active_reg, active_next;
    logic [CHANNELS-1:0] ev_valid_reg, ev_valid_next;
    logic [CHANNELS-1:0] ev_on_reg, ev_on_next;
    logic [CHANNELS-1:0] ev_end_reg, ev_end_next;
    logic [PW-1:0]   pos_reg [CHANNELS];
    logic [PW-1:0]   pos_next [CHANNELS];
    logic [15:0]     cd_reg [CHANNELS];
    logic [15:0]     cd_next [CHANNELS];
    logic [15:0]     cutoff_reg [CHANNELS];
    logic [15:0]     cutoff_next [CHANNELS];
    logic [15:0]     pitch_reg [CHANNELS];
    logic [15:0]     pitch_next [CHANNELS];

    logic [CW-1:0]       tidx;
    logic                track_ok;
    logic                chan_last;
    logic [CHANNELS-1:0] above_mask;
    logic                more_above;
    logic                advance;
    logic                rem_now;
    logic                do_arm;
    logic                emit_all;
    logic [15:0]         cd_dec;
    logic [15:0]         note_ivl;
    logic [15:0]         note_pit;

    // note_index modulo NOTES_PER_TRACK by restoring subtraction (quotient < 16)
    function automatic logic [PW-1:0] wrap_index(input logic [7:0] v);
        logic [15:0] r;
        r = 16'(v);
        for (int k = 3; k >= 0; k--)
        begin
            if (r >= 16'(NOTES_PER_TRACK << k))
            begin
                r = r - 16'(NOTES_PER_TRACK << k);
            end
        end
        return PW'(r);
    endfunction

    assign tidx      = CW'(req.track);
    assign track_ok  = int'(req.track) < CHANNELS;
    assign chan_last = ch_reg == CW'(CHANNELS - 1);
    assign busy      = state_reg != msq_pkg::ST_IDLE;
    assign cd_dec    = cd_reg[ch_reg] - 16'd1;
    assign note_ivl  = mem_rdata[15:0];
    assign note_pit  = mem_rdata[31:16];

    always_comb
    begin
        for (int i = 0; i < CHANNELS; i++)
        begin
            above_mask[i] = int'(ch_reg) < i;
        end
    end

    assign more_above = |(ev_valid_reg & above_mask);

    always_comb
    begin
        state_next    = state_reg;
        ch_next       = ch_reg;
        playing_next  = playing_reg;
        remain_next   = remain_reg;
        song_next     = song_reg;
        active_next   = active_reg;
        ev_valid_next = ev_valid_reg;
        ev_on_next    = ev_on_reg;
        ev_end_next   = ev_end_reg;
        pos_next      = pos_reg;
        cd_next       = cd_reg;
        cutoff_next   = cutoff_reg;
        pitch_next    = pitch_reg;
        mem_we        = 1'b0;
        mem_waddr     = AW'(tidx) * AW'(NOTES_PER_TRACK) + AW'(wrap_index(req.note_index));
        mem_wdata     = {req.pitch, req.interval};
        mem_re        = 1'b0;
        mem_raddr     = AW'(ch_reg) * AW'(NOTES_PER_TRACK) + AW'(pos_reg[ch_reg]);
        result_valid  = 1'b0;
        result        = '0;
        advance       = 1'b0;
        rem_now       = remain_reg;
        do_arm        = 1'b0;
        emit_all      = 1'b0;

        unique case (state_reg)
            msq_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    unique case (req.operation)
                        msq_pkg::OP_TICK:
                        begin
                            if (playing_reg)
                            begin
                                ev_valid_next = '0;
                                ev_on_next    = '0;
                                ev_end_next   = '0;
                                remain_next   = 1'b0;
                                song_next     = 1'b0;
                                ch_next       = '0;
                                state_next    = msq_pkg::ST_SCAN;
                            end
                        end
                        msq_pkg::OP_START:
                        begin
                            do_arm      = 1'b1;
                            emit_all    = 1'b1;
                            ev_end_next = '0;
                            song_next   = 1'b0;
                        end
                        msq_pkg::OP_PLAY:
                        begin
                            playing_next = 1'b1;
                        end
                        msq_pkg::OP_PAUSE:
                        begin
                            playing_next = 1'b0;
                            emit_all     = 1'b1;
                            ev_end_next  = '0;
                            song_next    = 1'b0;
                        end
                        msq_pkg::OP_LOAD:
                        begin
                            mem_we = track_ok;
                        end
                        msq_pkg::OP_LEGATO:
                        begin
                            if (track_ok)
                            begin
                                cutoff_next[tidx] = req.legato_ticks;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            msq_pkg::ST_SCAN:
            begin
                if (!active_reg[ch_reg])
                begin
                    advance = 1'b1;
                end
                else if (cd_reg[ch_reg] == 16'd0)
                begin
                    mem_re     = 1'b1;
                    state_next = msq_pkg::ST_NOTE;
                end
                else
                begin
                    cd_next[ch_reg] = cd_dec;
                    rem_now         = 1'b1;
                    remain_next     = 1'b1;
                    if (cd_dec == cutoff_reg[ch_reg])
                    begin
                        ev_valid_next[ch_reg] = 1'b1;
                    end
                    advance = 1'b1;
                end
            end
            msq_pkg::ST_NOTE:
            begin
                pos_next[ch_reg] = (pos_reg[ch_reg] == PW'(NOTES_PER_TRACK - 1)) ?
                                   '0 : pos_reg[ch_reg] + PW'(1);
                ev_valid_next[ch_reg] = 1'b1;
                if (note_ivl == 16'd0 && note_pit == 16'd0)
                begin
                    active_next[ch_reg] = 1'b0;
                    ev_end_next[ch_reg] = 1'b1;
                end
                else
                begin
                    cd_next[ch_reg]    = note_ivl - 16'd1;
                    rem_now            = 1'b1;
                    remain_next        = 1'b1;
                    ev_on_next[ch_reg] = note_pit != 16'd0;
                    pitch_next[ch_reg] = note_pit;
                end
                state_next = msq_pkg::ST_SCAN;
                advance    = 1'b1;
            end
            msq_pkg::ST_EMIT:
            begin
                if (ev_valid_reg[ch_reg])
                begin
                    result_valid      = 1'b1;
                    result.channel    = 2'(ch_reg);
                    result.sound_on   = ev_on_reg[ch_reg];
                    result.tone_pitch = ev_on_reg[ch_reg] ? pitch_reg[ch_reg] : 16'd0;
                    result.track_end  = ev_end_reg[ch_reg];
                    result.song_end   = song_reg && !more_above;
                    result.last       = !more_above;
                end
                if (!more_above)
                begin
                    state_next = msq_pkg::ST_IDLE;
                end
                else
                begin
                    ch_next = ch_reg + CW'(1);
                end
            end
            default:
            begin
                state_next = msq_pkg::ST_IDLE;
            end
        endcase

        if (advance)
        begin
            if (!chan_last)
            begin
                ch_next = ch_reg + CW'(1);
            end
            else if (!rem_now)
            begin
                // song over: re-arm, silence every channel, flag the final result
                playing_next = 1'b0;
                do_arm       = 1'b1;
                emit_all     = 1'b1;
                song_next    = 1'b1;
            end
            else if (ev_valid_next != '0)
            begin
                ch_next    = '0;
                state_next = msq_pkg::ST_EMIT;
            end
            else
            begin
                state_next = msq_pkg::ST_IDLE;
            end
        end

        if (do_arm)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                active_next[i] = 4'(i) < {1'b0, tracks_reg};
                pos_next[i]    = '0;
                cd_next[i]     = '0;
            end
        end

        if (emit_all)
        begin
            ev_valid_next = '1;
            ev_on_next    = '0;
            ch_next       = '0;
            state_next    = msq_pkg::ST_EMIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= msq_pkg::ST_IDLE;
            ch_reg       <= '0;
            playing_reg  <= 1'b0;
            tracks_reg   <= '0;
            remain_reg   <= 1'b0;
            song_reg     <= 1'b0;
            active_reg   <= '0;
            ev_valid_reg <= '0;
            ev_on_reg    <= '0;
            ev_end_reg   <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                pos_reg[i]    <= '0;
                cd_reg[i]     <= '0;
                cutoff_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            ch_reg       <= ch_next;
            playing_reg  <= playing_next;
            remain_reg   <= remain_next;
            song_reg     <= song_next;
            active_reg   <= active_next;
            ev_valid_reg <= ev_valid_next;
            ev_on_reg    <= ev_on_next;
            ev_end_reg   <= ev_end_next;
            pos_reg      <= pos_next;
            cd_reg       <= cd_next;
            cutoff_reg   <= cutoff_next;
            if (cfg_we)
            begin
                tracks_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pitch_reg <= pitch_next;
    end

endmodule

/* hdl/multi_track_note_sequencer.sv */
// Top level of the multi-track note sequencer.
// Instantiates msq_seq_ctrl and msq_note_mem; types from msq_pkg.
//
// One request is taken when start is high and busy is low; busy stays high
// until every result of that request has been shown. Results appear at most
// one per cycle on result with result_valid high for that single cycle and
// cannot be held off. Load note, set legato, play, the unused codes and a
// tick while paused give no result and leave busy low. Start and pause give
// one silence result for each of the CHANNELS channels. A tick scans the
// channels one per cycle, stopping in ST_NOTE for each track that fetches a
// note (the note memory read), then walks the channels up to the last event,
// one per cycle. The scan visits one channel at a time over the single read
// port of the note memory.
// No clearing pass follows reset.
module multi_track_note_sequencer #(
    parameter int CHANNELS        = msq_pkg::CHANNELS_DEF,
    parameter int NOTES_PER_TRACK = msq_pkg::NOTES_PER_TRACK_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  msq_pkg::req_t req,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_data,
    output logic          result_valid,
    output msq_pkg::rsp_t result
);

    localparam int DEPTH = CHANNELS * NOTES_PER_TRACK;
    localparam int AW    = $clog2(DEPTH);

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [31:0]   mem_rdata;

    msq_seq_ctrl #(
        .CHANNELS        (CHANNELS),
        .NOTES_PER_TRACK (NOTES_PER_TRACK),
        .AW              (AW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req          (req),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_re       (mem_re),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata),
        .result_valid (result_valid),
        .result       (result)
    );

    msq_note_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

/* tb/sv/tb_multi_track_note_sequencer.sv */
// Self-checking testbench for multi_track_note_sequencer: a directed request table, then
// randomized songs (note loads, legato, start/play/tick runs) checked against a behavioral
// predictor of the tracks. Depends on msq_pkg and the RTL under hdl/.
module tb_multi_track_note_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CH          = msq_pkg::CHANNELS_DEF;
    localparam int NPT         = msq_pkg::NOTES_PER_TRACK_DEF;
    localparam int HALF_PERIOD = 6;
    localparam int SETTLE      = 3 * CH + 4;
    localparam int WATCHDOG    = 2000;
    localparam int ITEM_TARGET = 210;
    localparam int DIR_ROWS    = 24;

    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    typedef enum {ROW_REQ, ROW_CFG} row_kind_t;
    typedef enum {EXP_MODEL, EXP_NONE, EXP_SILENCE, EXP_SONG_END} chk_t;

    typedef struct {
        row_kind_t   kind;
        logic [2:0]  cfg;
        logic [2:0]  op;
        logic [1:0]  trk;
        logic [7:0]  idx;
        logic [15:0] ivl;
        logic [15:0] pit;
        logic [15:0] leg;
        chk_t        chk;
    } row_t;

    logic          clk      = 1'b0;
    logic          rst_n    = 1'b0;
    logic          start    = 1'b0;
    msq_pkg::req_t req      = '0;
    logic          cfg_we   = 1'b0;
    logic [2:0]    cfg_data = 3'd0;
    logic          busy;
    logic          result_valid;
    msq_pkg::rsp_t result;

    // predictor state
    bit          trk_on   [CH];
    int          trk_pos  [CH];
    logic [15:0] trk_cnt  [CH];
    logic [15:0] trk_cut  [CH] = '{default: 16'h0};
    logic [31:0] note_mem [CH*NPT];
    bit          note_set [CH*NPT];
    bit          running   = 1'b0;
    logic [2:0]  armed_cfg = 3'd0;

    msq_pkg::rsp_t step_events [$];
    msq_pkg::rsp_t pending_events [$];
    int   err_count   = 0;
    int   req_count   = 0;
    int   idle_pct    = 0;
    int   quiet_cycles = 0;
    row_t dir_rows [DIR_ROWS];

    multi_track_note_sequencer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req          (req),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

    always #(HALF_PERIOD) clk = ~clk;

    function automatic msq_pkg::rsp_t make_event(int ch, bit on, logic [15:0] p, bit te,
                                                 bit se, bit lst);
        msq_pkg::rsp_t e;
        e.channel    = 2'(ch);
        e.sound_on   = on;
        e.tone_pitch = p;
        e.track_end  = te;
        e.song_end   = se;
        e.last       = lst;
        return e;
    endfunction

    function automatic void rearm();
        for (int i = 0; i < CH; i++)
        begin
            trk_on[i]  = (i < int'(armed_cfg));
            trk_pos[i] = 0;
            trk_cnt[i] = 16'h0;
        end
    endfunction

    function automatic void push_silence();
        for (int i = 0; i < CH; i++)
            step_events.push_back(make_event(i, 1'b0, 16'h0, 1'b0, 1'b0, 1'b0));
    endfunction

    function automatic void sequencer_step(msq_pkg::req_t r);
        bit          ended [CH];
        int          remaining;
        int          a;
        logic [31:0] w;
        step_events.delete();
        remaining = 0;
        case (r.operation)
            msq_pkg::OP_TICK:
            begin
                if (running)
                begin
                    for (int i = 0; i < CH; i++)
                    begin
                        ended[i] = 1'b0;
                        if (!trk_on[i])
                            continue;
                        if (trk_cnt[i] == 16'h0)
                        begin
                            a = i * NPT + trk_pos[i];
                            w = note_mem[a];
                            trk_pos[i] = (trk_pos[i] + 1) % NPT;
                            if (w == 32'h0)
                            begin
                                trk_on[i] = 1'b0;
                                ended[i]  = 1'b1;
                                step_events.push_back(
                                    make_event(i, 1'b0, 16'h0, 1'b1, 1'b0, 1'b0));
                            end
                            else
                            begin
                                trk_cnt[i] = w[15:0] - 16'd1;
                                remaining++;
                                if (w[31:16] != 16'h0)
                                    step_events.push_back(
                                        make_event(i, 1'b1, w[31:16], 1'b0, 1'b0, 1'b0));
                                else
                                    step_events.push_back(
                                        make_event(i, 1'b0, 16'h0, 1'b0, 1'b0, 1'b0));
                            end
                        end
                        else
                        begin
                            trk_cnt[i] = trk_cnt[i] - 16'd1;
                            remaining++;
                            if (trk_cnt[i] == trk_cut[i])
                                step_events.push_back(
                                    make_event(i, 1'b0, 16'h0, 1'b0, 1'b0, 1'b0));
                        end
                    end
                    if (remaining == 0)
                    begin
                        running = 1'b0;
                        rearm();
                        step_events.delete();
                        for (int i = 0; i < CH; i++)
                            step_events.push_back(
                                make_event(i, 1'b0, 16'h0, ended[i], i == CH - 1, 1'b0));
                    end
                end
            end
            msq_pkg::OP_START:
            begin
                rearm();
                push_silence();
            end
            msq_pkg::OP_PLAY:
                running = 1'b1;
            msq_pkg::OP_PAUSE:
            begin
                running = 1'b0;
                push_silence();
            end
            msq_pkg::OP_LOAD:
            begin
                if (int'(r.track) < CH)
                begin
                    a = int'(r.track) * NPT + int'(r.note_index) % NPT;
                    note_mem[a] = {r.pitch, r.interval};
                    note_set[a] = 1'b1;
                end
            end
            msq_pkg::OP_LEGATO:
            begin
                if (int'(r.track) < CH)
                    trk_cut[r.track] = r.legato_ticks;
            end
            default: ;
        endcase
        if (step_events.size() > 0)
            step_events[step_events.size() - 1].last = 1'b1;
    endfunction

    // address of a note the next tick would fetch before it was ever loaded, else -1
    function automatic int unread_note();
        for (int i = 0; i < CH; i++)
            if (running && trk_on[i] && trk_cnt[i] == 16'h0 && !note_set[i * NPT + trk_pos[i]])
                return i * NPT + trk_pos[i];
        return -1;
    endfunction

    function automatic msq_pkg::req_t rand_req(logic [2:0] op);
        msq_pkg::req_t r;
        r.operation    = op;
        r.track        = 2'($urandom);
        r.note_index   = 8'($urandom);
        r.interval     = 16'($urandom);
        r.pitch        = 16'($urandom);
        r.legato_ticks = 16'($urandom);
        return r;
    endfunction

    function automatic msq_pkg::req_t note_req(int t, int idx, logic [15:0] ivl,
                                               logic [15:0] pit);
        msq_pkg::req_t r;
        r            = rand_req(msq_pkg::OP_LOAD);
        r.track      = 2'(t);
        r.note_index = 8'(idx);
        r.interval   = ivl;
        r.pitch      = pit;
        return r;
    endfunction

    function automatic logic [15:0] rand_interval();
        case ($urandom_range(0, 15))
            0:       return 16'h0;
            1:       return 16'($urandom);
            default: return 16'($urandom_range(1, 3));
        endcase
    endfunction

    function automatic logic [15:0] rand_pitch();
        if ($urandom_range(0, 3) == 0)
            return 16'h0;
        return 16'($urandom_range(1, 65535));
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("[%0t] mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        err_count++;
    endtask

    task automatic issue(msq_pkg::req_t r, chk_t chk);
        while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start <= 1'b1;
        req   <= r;
        do
            @(posedge clk);
        while (busy);
        if (!(r.operation > msq_pkg::OP_LEGATO ||
              (r.operation == msq_pkg::OP_TICK && !running)))
            req_count++;
        sequencer_step(r);
        case (chk)
            EXP_MODEL:
                foreach (step_events[i])
                    pending_events.push_back(step_events[i]);
            EXP_SILENCE, EXP_SONG_END:
                for (int i = 0; i < CH; i++)
                    pending_events.push_back(make_event(i, 1'b0, 16'h0, 1'b0,
                        chk == EXP_SONG_END && i == CH - 1, i == CH - 1));
            default: ;
        endcase
    endtask

    task automatic drain_and_configure(logic [2:0] v);
        @(negedge clk);
        start <= 1'b0;
        while (pending_events.size() != 0 || busy)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        armed_cfg = v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_tick();
        int a;
        a = unread_note();
        while (a >= 0)
        begin
            if ($urandom_range(0, 1) == 0)
                issue(note_req(a / NPT, a % NPT, 16'h0, 16'h0), EXP_MODEL);
            else
                issue(note_req(a / NPT, a % NPT, rand_interval(), rand_pitch()), EXP_MODEL);
            a = unread_note();
        end
        issue(rand_req(msq_pkg::OP_TICK), EXP_MODEL);
    endtask

    task automatic run_song(logic [2:0] v);
        int            tracks;
        int            len;
        int            ticks;
        msq_pkg::req_t r;
        drain_and_configure(v);
        tracks = (int'(v) > CH) ? CH : int'(v);
        for (int t = 0; t < tracks; t++)
        begin
            len = $urandom_range(1, 4);
            for (int k = 0; k < len; k++)
                issue(note_req(t, k, rand_interval(), rand_pitch()), EXP_MODEL);
            issue(note_req(t, len, 16'h0, 16'h0), EXP_MODEL);
            r = rand_req(msq_pkg::OP_LEGATO);
            r.track = 2'(t);
            r.legato_ticks = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(0, 3));
            issue(r, EXP_MODEL);
        end
        issue(rand_req(msq_pkg::OP_START), EXP_MODEL);
        issue(rand_req(msq_pkg::OP_PLAY), EXP_MODEL);
        ticks = 0;
        while (running && ticks < 24 && req_count < ITEM_TARGET)
        begin
            case ($urandom_range(0, 19))
                0:
                begin
                    issue(rand_req(msq_pkg::OP_PAUSE), EXP_MODEL);
                    if ($urandom_range(0, 1) == 1)
                        issue(rand_req(msq_pkg::OP_PLAY), EXP_MODEL);
                end
                1: issue(rand_req(msq_pkg::OP_LOAD), EXP_MODEL);
                2: issue(rand_req(msq_pkg::OP_LEGATO), EXP_MODEL);
                3: issue(rand_req($urandom_range(0, 1) ? OP_RSVD6 : OP_RSVD7), EXP_MODEL);
                4: issue(rand_req(msq_pkg::OP_START), EXP_MODEL);
                default: send_tick();
            endcase
            ticks++;
        end
    endtask

    always @(posedge clk)
    begin
        msq_pkg::rsp_t want;
        if (rst_n && result_valid)
        begin
            if (pending_events.size() == 0)
                report_mismatch("result with nothing pending, channel",
                                16'(result.channel), 16'hffff);
            else
            begin
                want = pending_events.pop_front();
                if (result.channel !== want.channel)
                    report_mismatch("channel", 16'(result.channel), 16'(want.channel));
                if (result.sound_on !== want.sound_on)
                    report_mismatch("sound_on", 16'(result.sound_on), 16'(want.sound_on));
                if (result.tone_pitch !== want.tone_pitch)
                    report_mismatch("tone_pitch", result.tone_pitch, want.tone_pitch);
                if (result.track_end !== want.track_end)
                    report_mismatch("track_end", 16'(result.track_end), 16'(want.track_end));
                if (result.song_end !== want.song_end)
                    report_mismatch("song_end", 16'(result.song_end), 16'(want.song_end));
                if (result.last !== want.last)
                    report_mismatch("last", 16'(result.last), 16'(want.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("watchdog: no request or result for %0d cycles", WATCHDOG);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        msq_pkg::req_t r;
        int            song;
        logic [2:0]    v;

        dir_rows = '{
            '{ROW_REQ, 3'd0, msq_pkg::OP_TICK, 2'd0, 8'd0,
              16'h0000, 16'h0000, 16'h0000, EXP_NONE},
            '{ROW_REQ, 3'd0, OP_RSVD6, 2'd3, 8'd255,
              16'hffff, 16'hffff, 16'hffff, EXP_NONE},
            '{ROW_REQ, 3'd0, OP_RSVD7, 2'd3, 8'd255,
              16'hffff, 16'hffff, 16'hffff, EXP_NONE},
            '{ROW_REQ, 3'd0, msq_pkg::OP_PAUSE, 2'd0, 8'd0,
              16'h0000, 16'h0000, 16'h0000, EXP_SILENCE},
            '{ROW_REQ, 3'd0, msq_pkg::OP_PLAY, 2'd0, 8'd0,
              16'h0000, 16'h0000, 16'h0000, EXP_NONE},
            '{ROW_REQ, 3'd0, msq_pkg::OP_TICK, 2'd0, 8'd0,
              16'h0000, 16'h0000, 16'h0000, EXP_SONG_END},
            '{ROW_CFG, 3'd7, msq_pkg::OP_TICK, 2'd0, 8'd0,
              16'h0000, 16'h0000, 16'h0000, EXP_NONE},
            '{ROW_REQ, 3'd0, msq_pkg::OP_LOAD, 2'd0, 8'd0,
              16'hffff, 16'hffff, 16'h0000, EXP_NONE},
            '{ROW_REQ, 3'd0, msq_pkg::OP_LOAD, 2'd0, 8'd1,
              16'h0000, 16'h0000, 16'h0000, EXP_NONE},
            '{ROW_REQ, 3'd0, msq_pkg::OP_LOAD, 2'd1, 8'd0,
              16'h0000, 16'h1234, 16'h0000, EXP_NONE},
            '{ROW_REQ, 3'd0, msq_pkg::OP_LOAD, 2'd2, 8'd0,
              16'h0002, 16'h0000, 16'h0000, EXP_NONE},
            '{ROW_REQ, 3'd0, msq_pkg::OP_LOAD, 2'd2, 8'd1,
              16'h0000, 16'h0000, 16'h0000, EXP_NONE},
            '{ROW_REQ, 3'd0, msq_pkg::OP_LOAD, 2'd3, 8'd0,
              16'h0000, 16'h0000, 16'h0000, EXP_NONE},
            '{ROW_REQ, 3'd0, msq_pkg::OP_LOAD, 2'd3, 8'd255,
              16'h8000, 16'h8000, 16'h0000, EXP_NONE},
            '{ROW_REQ, 3'd0, msq_pkg::OP_LEGATO, 2'd0, 8'd0,
              16'h0000, 16'h0000, 16'hfffd, EXP_NONE},
            '{ROW_REQ, 3'd0, msq_pkg::OP_LEGATO, 2'd1, 8'd0,
              16'h0000, 16'h0000, 16'hffff, EXP_NONE},
            '{ROW_REQ, 3'd0, msq_pkg::OP_LEGATO, 2'd2, 8'd0,
              16'h0000, 16'h0000, 16'h0000, EXP_NONE},
            '{ROW_REQ, 3'd0, msq_pkg::OP_LEGATO, 2'd3, 8'd0,
              16'h0000, 16'h0000, 16'h5a5a, EXP_NONE},
            '{ROW_REQ, 3'd0, msq_pkg::OP_START, 2'd0, 8'd0,
              16'h0000, 16'h0000, 16'h0000, EXP_SILENCE},
            '{ROW_REQ, 3'd0, msq_pkg::OP_PLAY, 2'd0, 8'd0,
              16'h0000, 16'h0000, 16'h0000, EXP_NONE},
            '{ROW_REQ, 3'd0, msq_pkg::OP_TICK, 2'd0, 8'd0,
              16'h0000, 16'h0000, 16'h0000, EXP_MODEL},
            '{ROW_REQ, 3'd0, msq_pkg::OP_TICK, 2'd0, 8'd0,
              16'h0000, 16'h0000, 16'h0000, EXP_MODEL},
            '{ROW_REQ, 3'd0, msq_pkg::OP_TICK, 2'd0, 8'd0,
              16'h0000, 16'h0000, 16'h0000, EXP_MODEL},
            '{ROW_REQ, 3'd0, msq_pkg::OP_PAUSE, 2'd0, 8'd0,
              16'h0000, 16'h0000, 16'h0000, EXP_SILENCE}
        };

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        idle_pct = 14;
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
                drain_and_configure(dir_rows[i].cfg);
            else
            begin
                r.operation    = dir_rows[i].op;
                r.track        = dir_rows[i].trk;
                r.note_index   = dir_rows[i].idx;
                r.interval     = dir_rows[i].ivl;
                r.pitch        = dir_rows[i].pit;
                r.legato_ticks = dir_rows[i].leg;
                issue(r, dir_rows[i].chk);
            end
        end

        song = 0;
        while (req_count < ITEM_TARGET)
        begin
            idle_pct = (req_count < 90) ? 14 : (req_count < 150) ? 54 : 0;
            case (song)
                0:       v = 3'd4;
                1:       v = 3'd0;
                2:       v = 3'd7;
                default: v = 3'($urandom_range(0, 7));
            endcase
            run_song(v);
            song++;
        end

        @(negedge clk);
        start <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
